// ----- rtl/core/vdn_pkg.sv -----
// ----------------------------------------------------------------------------
// vdn_pkg: shared widths and stage counts
// Fixed-point widths for the direction normalizer datapath and the depths of
// the square root and divider pipelines.
// ----------------------------------------------------------------------------
package vdn_pkg;

   localparam int FIELD_W     = 16;
   localparam int DIFF_W      = FIELD_W + 1;          // to - from, exact
   localparam int ABS_W       = FIELD_W;              // |diff| <= 65535
   localparam int SQ_W        = 2 * ABS_W;
   localparam int SUM_W       = SQ_W + 2;             // three squares
   localparam int FRAC_EXT    = 16;                   // sum scaled by 2^16
   localparam int RAD_W       = SUM_W + FRAC_EXT;
   localparam int MAG_W       = RAD_W / 2;            // root bits
   localparam int SQRT_STAGES = MAG_W;                // one root bit per stage
   localparam int SQRT_REM_W  = MAG_W + 2;
   localparam int Q_W         = 15;                   // quotient <= 16384
   localparam int DIV_STAGES  = Q_W;                  // one quotient bit per stage
   localparam int DIV_REM_W   = MAG_W + 1;
   localparam int DIV_PRE_SH  = 22 - Q_W;             // |d| << 22 >> Q_W
   localparam int DLY_LEN     = SQRT_STAGES + 1;      // |d| wait for magnitude
   localparam int ZDLY_LEN    = SQRT_STAGES + DIV_STAGES;
   localparam int PIPE_LEN    = 3 + SQRT_STAGES + DIV_STAGES;

endpackage

// ----- rtl/core/vdn_sqrt.sv -----
// ----------------------------------------------------------------------------
// vdn_sqrt: pipelined integer square root
// Digit-by-digit root of (sum << 16), one root bit resolved per stage.
// ----------------------------------------------------------------------------
module vdn_sqrt (
   input  logic                      clock,
   input  logic                      adv,
   input  logic [vdn_pkg::SUM_W-1:0] sum,
   output logic [vdn_pkg::MAG_W-1:0] mag
);
   import vdn_pkg::*;

   logic [SQRT_REM_W-1:0] rem_ff  [SQRT_STAGES];
   logic [MAG_W-1:0]      root_ff [SQRT_STAGES];
   logic [RAD_W-1:0]      rad_ff  [SQRT_STAGES];
   logic [SQRT_REM_W-1:0] rem_in  [SQRT_STAGES];
   logic [MAG_W-1:0]      root_in [SQRT_STAGES];
   logic [RAD_W-1:0]      rad_in  [SQRT_STAGES];

   // one trial subtract per stage
   always_comb begin
      logic [SQRT_REM_W-1:0] s_rem;
      logic [MAG_W-1:0]      s_root;
      logic [RAD_W-1:0]      s_rad;
      logic [SQRT_REM_W+1:0] cur;
      logic [SQRT_REM_W+1:0] trial;
      for (int k = 0; k < SQRT_STAGES; k++) begin
         if (k == 0) begin
            s_rem  = '0;
            s_root = '0;
            s_rad  = {sum, {FRAC_EXT{1'b0}}};
         end else begin
            s_rem  = rem_ff[k-1];
            s_root = root_ff[k-1];
            s_rad  = rad_ff[k-1];
         end
         cur   = {s_rem, s_rad[RAD_W-1 -: 2]};
         trial = {1'b0, s_root, 2'b01};
         if (cur >= trial) begin
            rem_in[k]  = SQRT_REM_W'(cur - trial);
            root_in[k] = {s_root[MAG_W-2:0], 1'b1};
         end else begin
            rem_in[k]  = cur[SQRT_REM_W-1:0];
            root_in[k] = {s_root[MAG_W-2:0], 1'b0};
         end
         rad_in[k] = {s_rad[RAD_W-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < SQRT_STAGES; k++) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            rad_ff[k]  <= rad_in[k];
         end
      end
   end

   assign mag = root_ff[SQRT_STAGES-1];

endmodule

// ----- rtl/core/vdn_lane.sv -----
// ----------------------------------------------------------------------------
// vdn_lane: one axis of the normalizer
// Squares the component difference for the shared magnitude, holds |d| until
// the magnitude is ready, then divides it by the magnitude one bit per stage.
// ----------------------------------------------------------------------------
module vdn_lane (
   input  logic                             clock,
   input  logic                             adv,
   input  logic signed [vdn_pkg::DIFF_W-1:0] diff,
   input  logic [vdn_pkg::MAG_W-1:0]        mag,
   output logic [vdn_pkg::SQ_W-1:0]         sq,
   output logic signed [vdn_pkg::FIELD_W-1:0] dir
);
   import vdn_pkg::*;

   logic [ABS_W-1:0]     abs_ff;
   logic                 neg_ff;
   logic [SQ_W-1:0]      sq_ff;
   logic [ABS_W-1:0]     abs_in;
   logic [ABS_W-1:0]     dly_abs_ff [DLY_LEN];
   logic                 dly_neg_ff [DLY_LEN];
   logic [DIV_REM_W-1:0] rem_ff [DIV_STAGES];
   logic [MAG_W-1:0]     mag_ff [DIV_STAGES];
   logic [Q_W-1:0]       q_ff   [DIV_STAGES];
   logic                 dneg_ff[DIV_STAGES];
   logic [DIV_REM_W-1:0] rem_in [DIV_STAGES];
   logic [MAG_W-1:0]     mag_in [DIV_STAGES];
   logic [Q_W-1:0]       q_in   [DIV_STAGES];
   logic                 dneg_in[DIV_STAGES];
   logic [FIELD_W-1:0]   q_ext;

   // magnitude of the difference
   always_comb begin
      logic [DIFF_W-1:0] n;
      n      = diff[DIFF_W-1] ? DIFF_W'(-diff) : diff;
      abs_in = n[ABS_W-1:0];
   end

   // square stage and wait line
   always_ff @(posedge clock) begin
      if (adv) begin
         abs_ff <= abs_in;
         neg_ff <= diff[DIFF_W-1];
         sq_ff  <= abs_in * abs_in;
         dly_abs_ff[0] <= abs_ff;
         dly_neg_ff[0] <= neg_ff;
         for (int k = 1; k < DLY_LEN; k++) begin
            dly_abs_ff[k] <= dly_abs_ff[k-1];
            dly_neg_ff[k] <= dly_neg_ff[k-1];
         end
      end
   end

   // restoring divide, one quotient bit per stage
   always_comb begin
      logic [DIV_REM_W-1:0] s_rem;
      logic [MAG_W-1:0]     s_mag;
      logic [Q_W-1:0]       s_q;
      logic                 s_neg;
      logic [DIV_REM_W:0]   cur;
      for (int k = 0; k < DIV_STAGES; k++) begin
         if (k == 0) begin
            s_rem = DIV_REM_W'({dly_abs_ff[DLY_LEN-1], {DIV_PRE_SH{1'b0}}});
            s_mag = mag;
            s_q   = '0;
            s_neg = dly_neg_ff[DLY_LEN-1];
         end else begin
            s_rem = rem_ff[k-1];
            s_mag = mag_ff[k-1];
            s_q   = q_ff[k-1];
            s_neg = dneg_ff[k-1];
         end
         cur = {s_rem, 1'b0};
         if (cur >= {2'b00, s_mag}) begin
            rem_in[k] = DIV_REM_W'(cur - {2'b00, s_mag});
            q_in[k]   = {s_q[Q_W-2:0], 1'b1};
         end else begin
            rem_in[k] = cur[DIV_REM_W-1:0];
            q_in[k]   = {s_q[Q_W-2:0], 1'b0};
         end
         mag_in[k]  = s_mag;
         dneg_in[k] = s_neg;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < DIV_STAGES; k++) begin
            rem_ff[k]  <= rem_in[k];
            mag_ff[k]  <= mag_in[k];
            q_ff[k]    <= q_in[k];
            dneg_ff[k] <= dneg_in[k];
         end
      end
   end

   // restore the sign: truncation toward zero
   assign q_ext = {1'b0, q_ff[DIV_STAGES-1]};
   assign dir   = dneg_ff[DIV_STAGES-1] ? FIELD_W'(-q_ext) : q_ext;
   assign sq    = sq_ff;

endmodule

// ----- rtl/core/vector_direction_normalise_top.sv -----
// ----------------------------------------------------------------------------
// vector_direction_normalise_top: unit direction between two 3D points
// Throughput: one word per cycle; the 25-stage root and 15-stage divide
// pipelines each take a new word every cycle. The whole pipe holds on a
// stalled response. Reset clears the valid bits only.
// ----------------------------------------------------------------------------
module vector_direction_normalise_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [15:0]  req_from_x,
   input  logic signed [15:0]  req_from_y,
   input  logic signed [15:0]  req_from_z,
   input  logic signed [15:0]  req_to_x,
   input  logic signed [15:0]  req_to_y,
   input  logic signed [15:0]  req_to_z,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [15:0]  rsp_dir_x,
   output logic signed [15:0]  rsp_dir_y,
   output logic signed [15:0]  rsp_dir_z,
   output logic                rsp_zero_vector
);
   import vdn_pkg::*;

   logic                      adv;
   logic [PIPE_LEN-1:0]       pipe_v_ff;
   logic signed [DIFF_W-1:0]  dx_ff, dy_ff, dz_ff;
   logic [SQ_W-1:0]           sq_x, sq_y, sq_z;
   logic [SUM_W-1:0]          sum_ff;
   logic                      zero_ff;
   logic                      zdly_ff [ZDLY_LEN];
   logic [MAG_W-1:0]          mag;
   logic signed [FIELD_W-1:0] dir_x, dir_y, dir_z;
   logic                      rsp_valid_ff;
   logic signed [FIELD_W-1:0] rsp_dir_x_ff, rsp_dir_y_ff, rsp_dir_z_ff;
   logic                      rsp_zero_ff;

   // pipe moves whenever the output register is free or being emptied
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_v_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         pipe_v_ff    <= {pipe_v_ff[PIPE_LEN-2:0], req_valid};
         rsp_valid_ff <= pipe_v_ff[PIPE_LEN-1];
      end
   end

   // difference stage
   always_ff @(posedge clock) begin
      if (adv) begin
         dx_ff <= DIFF_W'(req_to_x) - DIFF_W'(req_from_x);
         dy_ff <= DIFF_W'(req_to_y) - DIFF_W'(req_from_y);
         dz_ff <= DIFF_W'(req_to_z) - DIFF_W'(req_from_z);
      end
   end

   vdn_lane u_lane_x (.clock(clock), .adv(adv), .diff(dx_ff), .mag(mag),
                      .sq(sq_x), .dir(dir_x));
   vdn_lane u_lane_y (.clock(clock), .adv(adv), .diff(dy_ff), .mag(mag),
                      .sq(sq_y), .dir(dir_y));
   vdn_lane u_lane_z (.clock(clock), .adv(adv), .diff(dz_ff), .mag(mag),
                      .sq(sq_z), .dir(dir_z));

   // merge the lane squares; zero flag follows the word down the pipe
   always_ff @(posedge clock) begin
      if (adv) begin
         sum_ff     <= SUM_W'(sq_x) + SUM_W'(sq_y) + SUM_W'(sq_z);
         zero_ff    <= (sq_x == '0) && (sq_y == '0) && (sq_z == '0);
         zdly_ff[0] <= zero_ff;
         for (int k = 1; k < ZDLY_LEN; k++) begin
            zdly_ff[k] <= zdly_ff[k-1];
         end
      end
   end

   vdn_sqrt u_sqrt (.clock(clock), .adv(adv), .sum(sum_ff), .mag(mag));

   // output register
   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_zero_ff  <= zdly_ff[ZDLY_LEN-1];
         rsp_dir_x_ff <= zdly_ff[ZDLY_LEN-1] ? '0 : dir_x;
         rsp_dir_y_ff <= zdly_ff[ZDLY_LEN-1] ? '0 : dir_y;
         rsp_dir_z_ff <= zdly_ff[ZDLY_LEN-1] ? '0 : dir_z;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_dir_x       = rsp_dir_x_ff;
   assign rsp_dir_y       = rsp_dir_y_ff;
   assign rsp_dir_z       = rsp_dir_z_ff;
   assign rsp_zero_vector = rsp_zero_ff;

   // zero flag forces a zero direction
   a_zero_dir: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_vector |->
         rsp_dir_x == 16'sd0 && rsp_dir_y == 16'sd0 && rsp_dir_z == 16'sd0)
      else $error("zero flag with nonzero direction");

   // components stay within the unit range
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         rsp_dir_x <= 16'sd16384 && rsp_dir_x >= -16'sd16384 &&
         rsp_dir_y <= 16'sd16384 && rsp_dir_y >= -16'sd16384 &&
         rsp_dir_z <= 16'sd16384 && rsp_dir_z >= -16'sd16384)
      else $error("direction component out of range");

   // request side stalls only behind a held response
   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("request stall without held response");

   // a held response does not lose the word behind it
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("held response dropped");

endmodule

// ----- dv/tb_direction_checker.sv -----
// ----------------------------------------------------------------------------
// tb_direction_checker: response predictor and scoreboard
// Watches the request and response channels of the direction normalizer.
// For each accepted request word it computes the expected unit direction,
// and compares each accepted response word with the oldest expectation.
// ----------------------------------------------------------------------------
module tb_direction_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [15:0] req_from_x,
   input  logic signed [15:0] req_from_y,
   input  logic signed [15:0] req_from_z,
   input  logic signed [15:0] req_to_x,
   input  logic signed [15:0] req_to_y,
   input  logic signed [15:0] req_to_z,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [15:0] rsp_dir_x,
   input  logic signed [15:0] rsp_dir_y,
   input  logic signed [15:0] rsp_dir_z,
   input  logic               rsp_zero_vector,
   output int                 fail_count,
   output int                 pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [15:0] dir_x;
      logic [15:0] dir_y;
      logic [15:0] dir_z;
      logic        zero_vector;
   } direction_type;

   direction_type expected_dirs[$];

   // floor square root, one result bit per pass
   function automatic longint unsigned floor_sqrt(longint unsigned n);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n    = n - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   // Q1.14 component, truncated toward zero
   function automatic logic [15:0] unit_component(longint d, longint unsigned mag);
      longint unsigned q;
      q = ((d < 0 ? -d : d) << 22) / mag;
      if (d < 0) q = -q;
      return q[15:0];
   endfunction

   function automatic direction_type predict_direction(
      logic signed [15:0] fx, logic signed [15:0] fy, logic signed [15:0] fz,
      logic signed [15:0] tx, logic signed [15:0] ty, logic signed [15:0] tz);
      longint          dx, dy, dz;
      longint unsigned sum, mag;
      direction_type   r;
      dx = longint'(tx) - longint'(fx);
      dy = longint'(ty) - longint'(fy);
      dz = longint'(tz) - longint'(fz);
      if (dx == 0 && dy == 0 && dz == 0) begin
         r = '{16'd0, 16'd0, 16'd0, 1'b1};
      end else begin
         sum = dx * dx + dy * dy + dz * dz;
         mag = floor_sqrt(sum << 16);
         r.dir_x       = unit_component(dx, mag);
         r.dir_y       = unit_component(dy, mag);
         r.dir_z       = unit_component(dz, mag);
         r.zero_vector = 1'b0;
      end
      return r;
   endfunction

   assign pending_count = expected_dirs.size();

   // predict on request, compare on response
   always @(posedge clock) begin
      direction_type exp_dir;
      if (!reset) begin
         if (req_valid && !req_stall)
            expected_dirs.push_back(predict_direction(req_from_x, req_from_y, req_from_z,
                                                      req_to_x, req_to_y, req_to_z));
         if (rsp_valid && !rsp_stall) begin
            if (expected_dirs.size() == 0) begin
               $display("%0t: unexpected response word x=%0d y=%0d z=%0d zero=%0b",
                        $time, rsp_dir_x, rsp_dir_y, rsp_dir_z, rsp_zero_vector);
               fail_count++;
            end else begin
               exp_dir = expected_dirs.pop_front();
               if (exp_dir.dir_x !== rsp_dir_x) begin
                  $display("%0t: dir_x expected %0d actual %0d", $time,
                           $signed(exp_dir.dir_x), rsp_dir_x);
                  fail_count++;
               end
               if (exp_dir.dir_y !== rsp_dir_y) begin
                  $display("%0t: dir_y expected %0d actual %0d", $time,
                           $signed(exp_dir.dir_y), rsp_dir_y);
                  fail_count++;
               end
               if (exp_dir.dir_z !== rsp_dir_z) begin
                  $display("%0t: dir_z expected %0d actual %0d", $time,
                           $signed(exp_dir.dir_z), rsp_dir_z);
                  fail_count++;
               end
               if (exp_dir.zero_vector !== rsp_zero_vector) begin
                  $display("%0t: zero_vector expected %0b actual %0b", $time,
                           exp_dir.zero_vector, rsp_zero_vector);
                  fail_count++;
               end
            end
         end
      end
   end

   initial fail_count = 0;

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: direction normalizer testbench
// Drives directed corner points and then random point pairs, with bursty
// requests, patterned response stalls and one long hold-off to back up the
// pipe. The checker module predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY    = 43;
   localparam int RAND_WORDS = 264;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [15:0] req_from_x, req_from_y, req_from_z;
   logic signed [15:0] req_to_x, req_to_y, req_to_z;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [15:0] rsp_dir_x, rsp_dir_y, rsp_dir_z;
   logic               rsp_zero_vector;
   int                 fail_count;
   int                 pending_count;
   bit                 long_hold;

   vector_direction_normalise_top u_top (.*);

   tb_direction_checker u_checker (.*);

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // send one request word, waiting for acceptance
   task automatic send_points(logic [15:0] fx, logic [15:0] fy, logic [15:0] fz,
                              logic [15:0] tx, logic [15:0] ty, logic [15:0] tz);
      req_valid  <= 1'b1;
      req_from_x <= fx;
      req_from_y <= fy;
      req_from_z <= fz;
      req_to_x   <= tx;
      req_to_y   <= ty;
      req_to_z   <= tz;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   function automatic logic [15:0] rand_coord();
      case ($urandom_range(0, 5))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'($urandom_range(0, 15)) - 16'd8;
         default: return 16'($urandom);
      endcase
   endfunction

   // receiver stall pattern, plus one long hold-off
   initial begin
      int pat;
      rsp_stall = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (150) @(posedge clock);
            long_hold = 1'b0;
            rsp_stall <= 1'b0;
         end else begin
            pat = $urandom_range(0, 7);
            rsp_stall <= (pat < 3);
         end
      end
   end

   initial begin
      logic [15:0] fx, fy, fz;
      int          mode;
      int          burst;
      req_valid  = 1'b0;
      req_from_x = '0;
      req_from_y = '0;
      req_from_z = '0;
      req_to_x   = '0;
      req_to_y   = '0;
      req_to_z   = '0;
      long_hold  = 1'b0;
      reset      = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners: equal points, single axis, extremes
      send_points(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_points(16'h8000, 16'h7FFF, 16'h1234, 16'h8000, 16'h7FFF, 16'h1234);
      send_points(16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'h0000);
      send_points(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFF00, 16'h0000);
      send_points(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0001);
      send_points(16'h8000, 16'h0000, 16'h0000, 16'h7FFF, 16'h0000, 16'h0000);
      send_points(16'h7FFF, 16'h0000, 16'h0000, 16'h8000, 16'h0000, 16'h0000);
      send_points(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_points(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000);
      send_points(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
      send_points(16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0001, 16'h0001);
      send_points(16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'h0001, 16'h0000);
      send_points(16'h0000, 16'h0000, 16'h0000, 16'h0003, 16'h0004, 16'h0000);
      send_points(16'hFFFF, 16'h8000, 16'h0001, 16'h0000, 16'h8001, 16'h0000);
      send_points(16'h5555, 16'hAAAA, 16'h0F0F, 16'hAAAA, 16'h5555, 16'hF0F0);
      send_points(16'h0000, 16'h0000, 16'h7FFF, 16'h0000, 16'h0000, 16'h8000);

      // long receiver hold-off while requests keep coming
      long_hold = 1'b1;
      repeat (120)
         send_points(16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), 16'($urandom), 16'($urandom));

      // random bursts with random gaps
      for (int n = 0; n < RAND_WORDS; ) begin
         burst = $urandom_range(1, 20);
         for (int b = 0; b < burst; b++, n++) begin
            mode = $urandom_range(0, 9);
            fx = rand_coord();
            fy = rand_coord();
            fz = rand_coord();
            if (mode == 0)
               send_points(fx, fy, fz, fx, fy, fz);
            else if (mode == 1)
               send_points(fx, fy, fz, fx + 16'($urandom_range(0, 3)) - 16'd1, fy, fz);
            else
               send_points(fx, fy, fz, rand_coord(), rand_coord(), rand_coord());
         end
         if ($urandom_range(0, 2) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
      req_valid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // watchdog
   initial begin
      #2ms;
      $display("Regression FAIL");
      $finish;
   end

endmodule

// ----- vector_direction_normalise_top.f -----
rtl/core/vdn_pkg.sv
rtl/core/vdn_sqrt.sv
rtl/core/vdn_lane.sv
rtl/core/vector_direction_normalise_top.sv
dv/tb_direction_checker.sv
dv/tb_top.sv
